[rtl/grid_clearance_map_engine_core_assert.svh]
// assertion helpers, clocked on clk, quiet while arst_n is low
`ifndef GRID_CLEARANCE_MAP_ENGINE_CORE_ASSERT_SVH
`define GRID_CLEARANCE_MAP_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define GCME_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gcme assertion failed");

// next-cycle implication
`define GCME_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcme assertion failed");

`endif

[rtl/gcme_pkg.sv]
package gcme_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_TILE_BITS  = 16;

	// internal coordinates, counts and grid size registers share one width
	localparam int CNT_W = 7;

	localparam logic [CNT_W-1:0] CFG_RESET = 7'd64;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_REBUILD = 2'd2;

	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_OUTSIDE = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [15:0] tile_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] tile_code;
		logic [6:0]  column_clearance;
		logic [6:0]  row_clearance;
		logic        status;
	} out_item_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic check;
		logic walk_issue;
		logic final_read;
		logic load_out;
	} gcme_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rebuild;
		logic in_grid;
		logic write_change;
		logic walk_last;
		logic out_free;
	} gcme_stat_t;

endpackage

[rtl/grid_clearance_map_engine_core.sv]
// Accept to output register: a read or unchanged write gets a final read, an outside
// coordinate none; a solidity-changing write first walks (x+1) + (y+1) cells,
// a rebuild 2*w*h cells. The walk issues one tile-memory read per cell; only one item
// is in flight, so the next is accepted after the result load. Reset: asynchronous
// arst_n, then a clearing pass over MAX_WIDTH*MAX_HEIGHT cells (4096 by default)
// zeroes the tile and count memories while in_stall stays high.
`include "grid_clearance_map_engine_core_assert.svh"

module grid_clearance_map_engine_core #(
	parameter int MAX_WIDTH  = gcme_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gcme_pkg::DEF_MAX_HEIGHT,
	parameter int TILE_BITS  = gcme_pkg::DEF_TILE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  gcme_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gcme_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [gcme_pkg::CNT_W-1:0] cfg_data
);

	gcme_pkg::gcme_cmd_t  cmd;
	gcme_pkg::gcme_stat_t stat;

	gcme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	gcme_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.TILE_BITS  (TILE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	// an accepted beat is always decoded in the following cycle
	`GCME_ASSERT_NXT(a_accept_then_check, in_valid && !in_stall, cmd.check)
	// a result never overwrites one still waiting downstream
	`GCME_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid || !out_stall)
	// no beat is taken while the memories are being cleared
	`GCME_ASSERT_IMP(a_clear_stalls, cmd.clr_step, in_stall)

endmodule

[rtl/gcme_ctrl.sv]
module gcme_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gcme_pkg::gcme_stat_t stat,
	output gcme_pkg::gcme_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_WALK  = 7'b0001000,
		S_DRAIN = 7'b0010000,
		S_READ  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.rebuild) state_nxt = S_WALK;
				else if (!stat.in_grid) state_nxt = S_RESP;
				else if (stat.write_change) state_nxt = S_WALK;
				else state_nxt = S_READ;
			end
			S_WALK: begin
				cmd.walk_issue = 1'b1;
				if (stat.walk_last) state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				state_nxt = S_READ;
			end
			S_READ: begin
				cmd.final_read = 1'b1;
				state_nxt      = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

endmodule

[rtl/gcme_dp.sv]
module gcme_dp #(
	parameter int MAX_WIDTH  = gcme_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gcme_pkg::DEF_MAX_HEIGHT,
	parameter int TILE_BITS  = gcme_pkg::DEF_TILE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gcme_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output gcme_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [gcme_pkg::CNT_W-1:0]     cfg_data,
	input  gcme_pkg::gcme_cmd_t            cmd,
	output gcme_pkg::gcme_stat_t           stat
);

	localparam int CW    = gcme_pkg::CNT_W;
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CMAX  = (1 << CW) - 1;
	localparam logic [CW-1:0] WCAP = CW'((MAX_WIDTH < CMAX) ? MAX_WIDTH : CMAX);
	localparam logic [CW-1:0] HCAP = CW'((MAX_HEIGHT < CMAX) ? MAX_HEIGHT : CMAX);
	localparam logic DIR_COL = 1'b0;
	localparam logic DIR_ROW = 1'b1;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
		input logic [CW-1:0] cy);
		return AW'(int'(cx) * MAX_HEIGHT + int'(cy));
	endfunction

	logic [TILE_BITS-1:0] tile_mem [CELLS];
	logic [CW-1:0]        col_mem  [CELLS];
	logic [CW-1:0]        row_mem  [CELLS];

	logic [CW-1:0] width_q, height_q, w_eff, h_eff;
	gcme_pkg::in_item_t item_q;
	logic [AW-1:0] item_addr_q;
	logic [CW-1:0] x_q, y_q, in_x, in_y;
	logic [AW-1:0] acc_addr, col_next, row_next;
	logic [TILE_BITS-1:0] tv;
	logic is_write, is_rebuild, in_grid, sol_change;

	logic [AW-1:0] clr_cnt_q;

	logic          mode_rb_q, dir_q, first_q;
	logic [CW-1:0] fix_q, pos_q;
	logic [AW-1:0] walk_addr;
	logic          chain_end;
	logic [CW-1:0] col_seed_q, row_seed_q, prev_q;

	logic          valid_s1, dir_s1, first_s1;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] prev, lim, run_new;
	logic [CW:0]   inc;

	logic [TILE_BITS-1:0] tile_rd_q;
	logic [CW-1:0]        col_rd_q, row_rd_q;

	logic                 tile_we, tile_re, col_we, col_re, row_we, row_re;
	logic [AW-1:0]        tile_wa, tile_ra, col_wa, col_ra, row_wa, row_ra;
	logic [TILE_BITS-1:0] tile_wd;
	logic [CW-1:0]        run_wd;

	logic out_valid_q;
	gcme_pkg::out_item_t out_data_q, out_next;

	// grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gcme_pkg::CFG_RESET;
			height_q <= gcme_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gcme_pkg::REG_GRID_WIDTH:  width_q  <= cfg_data;
				gcme_pkg::REG_GRID_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q == '0) ? CW'(1) : ((width_q > WCAP) ? WCAP : width_q);
	assign h_eff = (height_q == '0) ? CW'(1) : ((height_q > HCAP) ? HCAP : height_q);

	// item capture
	assign in_x     = CW'(in_data.cell_x);
	assign in_y     = CW'(in_data.cell_y);
	assign acc_addr = cell_addr(in_x, in_y);
	assign col_next = cell_addr(in_x, in_y + CW'(1));
	assign row_next = cell_addr(in_x + CW'(1), in_y);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q      <= in_data;
			item_addr_q <= acc_addr;
		end
	end

	assign x_q        = CW'(item_q.cell_x);
	assign y_q        = CW'(item_q.cell_y);
	assign tv         = TILE_BITS'(item_q.tile_value);
	assign is_write   = (item_q.operation == gcme_pkg::OP_WRITE);
	assign is_rebuild = (item_q.operation == gcme_pkg::OP_REBUILD);
	assign in_grid    = (x_q < w_eff) && (y_q < h_eff);
	assign sol_change = (tile_rd_q != '0) != (tv != '0);

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// chain walker: column chains then row chains, each from pos down to 0
	assign walk_addr = (dir_q == DIR_COL) ? cell_addr(fix_q, pos_q) : cell_addr(pos_q, fix_q);
	assign chain_end = (pos_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_rb_q <= 1'b0;
			dir_q     <= DIR_COL;
			first_q   <= 1'b1;
			fix_q     <= '0;
			pos_q     <= '0;
		end else if (cmd.check) begin
			first_q <= 1'b1;
			dir_q   <= DIR_COL;
			if (is_rebuild) begin
				mode_rb_q <= 1'b1;
				fix_q     <= '0;
				pos_q     <= h_eff - CW'(1);
			end else begin
				mode_rb_q <= 1'b0;
				fix_q     <= x_q;
				pos_q     <= y_q;
			end
		end else if (cmd.walk_issue) begin
			if (!chain_end) begin
				pos_q   <= pos_q - CW'(1);
				first_q <= 1'b0;
			end else begin
				first_q <= 1'b1;
				if (dir_q == DIR_COL) begin
					if (mode_rb_q && (fix_q != w_eff - CW'(1))) begin
						fix_q <= fix_q + CW'(1);
						pos_q <= h_eff - CW'(1);
					end else if (mode_rb_q) begin
						dir_q <= DIR_ROW;
						fix_q <= '0;
						pos_q <= w_eff - CW'(1);
					end else begin
						dir_q <= DIR_ROW;
						fix_q <= y_q;
						pos_q <= x_q;
					end
				end else begin
					fix_q <= fix_q + CW'(1);
					pos_q <= w_eff - CW'(1);
				end
			end
		end
	end

	// seeds: neighbor counts for a write, edge for a rebuild
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			if (is_rebuild || (y_q + CW'(1) >= h_eff)) col_seed_q <= '0;
			else col_seed_q <= col_rd_q;
			if (is_rebuild || (x_q + CW'(1) >= w_eff)) row_seed_q <= '0;
			else row_seed_q <= row_rd_q;
		end
	end

	// stage 1: tile data back, new count computed and written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_issue) begin
			dir_s1   <= dir_q;
			first_s1 <= first_q;
			addr_s1  <= walk_addr;
		end
		if (valid_s1) prev_q <= run_new;
	end

	always_comb begin
		if (first_s1) prev = (dir_s1 == DIR_COL) ? col_seed_q : row_seed_q;
		else prev = prev_q;
		lim = (dir_s1 == DIR_COL) ? h_eff : w_eff;
		inc = {1'b0, prev} + (CW+1)'(1);
		if (tile_rd_q != '0) run_new = '0;
		else if (inc > {1'b0, lim}) run_new = lim;
		else run_new = inc[CW-1:0];
	end

	// memory port selection
	assign tile_we = cmd.clr_step || (cmd.check && is_write && in_grid);
	assign tile_wa = cmd.clr_step ? clr_cnt_q : item_addr_q;
	assign tile_wd = cmd.clr_step ? '0 : tv;
	assign tile_re = cmd.accept || cmd.walk_issue || cmd.final_read;
	assign tile_ra = cmd.accept ? acc_addr : (cmd.walk_issue ? walk_addr : item_addr_q);

	assign run_wd = cmd.clr_step ? '0 : run_new;
	assign col_we = cmd.clr_step || (valid_s1 && (dir_s1 == DIR_COL));
	assign row_we = cmd.clr_step || (valid_s1 && (dir_s1 == DIR_ROW));
	assign col_wa = cmd.clr_step ? clr_cnt_q : addr_s1;
	assign row_wa = cmd.clr_step ? clr_cnt_q : addr_s1;
	assign col_re = cmd.accept || cmd.final_read;
	assign row_re = cmd.accept || cmd.final_read;
	assign col_ra = cmd.accept ? col_next : item_addr_q;
	assign row_ra = cmd.accept ? row_next : item_addr_q;

	always_ff @(posedge clk) begin
		if (tile_we) tile_mem[tile_wa] <= tile_wd;
		if (tile_re) tile_rd_q <= tile_mem[tile_ra];
	end

	always_ff @(posedge clk) begin
		if (col_we) col_mem[col_wa] <= run_wd;
		if (col_re) col_rd_q <= col_mem[col_ra];
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_wa] <= run_wd;
		if (row_re) row_rd_q <= row_mem[row_ra];
	end

	// output register
	always_comb begin
		if (in_grid) begin
			out_next.tile_code        = 16'(tile_rd_q);
			out_next.column_clearance = col_rd_q;
			out_next.row_clearance    = row_rd_q;
			out_next.status           = gcme_pkg::ST_DONE;
		end else begin
			out_next.tile_code        = '0;
			out_next.column_clearance = '0;
			out_next.row_clearance    = '0;
			out_next.status           = gcme_pkg::ST_OUTSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) out_data_q <= out_next;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign stat.clr_last     = (clr_cnt_q == AW'(CELLS - 1));
	assign stat.rebuild      = is_rebuild;
	assign stat.in_grid      = in_grid;
	assign stat.write_change = is_write && in_grid && sol_change;
	assign stat.walk_last    = chain_end && (dir_q == DIR_ROW)
		&& (!mode_rb_q || (fix_q == h_eff - CW'(1)));
	assign stat.out_free     = !out_valid_q || !out_stall;

endmodule

[tb/grid_clearance_map_engine_core_tb.sv]
`timescale 1ns / 1ps

module grid_clearance_map_engine_core_tb;

	localparam int MAXW  = gcme_pkg::DEF_MAX_WIDTH;
	localparam int MAXH  = gcme_pkg::DEF_MAX_HEIGHT;
	localparam int CELLS = MAXW * MAXH;
	localparam logic [1:0] OP_SPARE = 2'd3;

	class clearance_scoreboard;
		logic [15:0]                tiles [CELLS];
		logic [gcme_pkg::CNT_W-1:0] col_run [CELLS];
		logic [gcme_pkg::CNT_W-1:0] row_run [CELLS];
		logic [gcme_pkg::CNT_W-1:0] width_reg;
		logic [gcme_pkg::CNT_W-1:0] height_reg;
		gcme_pkg::out_item_t        expected_cells [$];
		int                         errors;

		function new();
			foreach (tiles[i]) begin
				tiles[i]   = '0;
				col_run[i] = '0;
				row_run[i] = '0;
			end
			width_reg  = gcme_pkg::CFG_RESET;
			height_reg = gcme_pkg::CFG_RESET;
			errors     = 0;
		endfunction

		function int unsigned eff_w();
			if (width_reg == 0) return 1;
			if (width_reg > MAXW) return MAXW;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			if (height_reg == 0) return 1;
			if (height_reg > MAXH) return MAXH;
			return height_reg;
		endfunction

		function void set_reg(logic idx, logic [gcme_pkg::CNT_W-1:0] val);
			if (idx == gcme_pkg::REG_GRID_WIDTH) width_reg = val;
			else height_reg = val;
		endfunction

		function int pending();
			return expected_cells.size();
		endfunction

		function void fix_column(int unsigned x, int unsigned y, int unsigned h);
			int unsigned i;
			int unsigned v;
			i = x * MAXH + y;
			if (tiles[i] != 0) v = 0;
			else if (y + 1 >= h) v = 1;
			else begin
				v = col_run[i + 1] + 1;
				if (v > h) v = h;
			end
			col_run[i] = v[gcme_pkg::CNT_W-1:0];
		endfunction

		function void fix_row(int unsigned x, int unsigned y, int unsigned w);
			int unsigned i;
			int unsigned v;
			i = x * MAXH + y;
			if (tiles[i] != 0) v = 0;
			else if (x + 1 >= w) v = 1;
			else begin
				v = row_run[i + MAXH] + 1;
				if (v > w) v = w;
			end
			row_run[i] = v[gcme_pkg::CNT_W-1:0];
		endfunction

		function void rebuild_counts(int unsigned w, int unsigned h);
			for (int x = 0; x < w; x++)
				for (int y = h - 1; y >= 0; y--)
					fix_column(x, y, h);
			for (int y = 0; y < h; y++)
				for (int x = w - 1; x >= 0; x--)
					fix_row(x, y, w);
		endfunction

		function void note_request(gcme_pkg::in_item_t req);
			int unsigned w, h, x, y, i;
			logic was_solid, now_solid;
			gcme_pkg::out_item_t want;
			w = eff_w();
			h = eff_h();
			x = req.cell_x;
			y = req.cell_y;
			want = '0;
			if (req.operation == gcme_pkg::OP_REBUILD) rebuild_counts(w, h);
			if (x >= w || y >= h) begin
				want.status = gcme_pkg::ST_OUTSIDE;
				expected_cells = {expected_cells, want};
				return;
			end
			i = x * MAXH + y;
			if (req.operation == gcme_pkg::OP_WRITE) begin
				was_solid = tiles[i] != 0;
				now_solid = req.tile_value != 0;
				tiles[i] = req.tile_value;
				if (was_solid != now_solid) begin
					fix_column(x, y, h);
					fix_row(x, y, w);
					for (int k = int'(y) - 1; k >= 0; k--) fix_column(x, k, h);
					for (int k = int'(x) - 1; k >= 0; k--) fix_row(k, y, w);
				end
			end
			want.tile_code        = tiles[i];
			want.column_clearance = col_run[i];
			want.row_clearance    = row_run[i];
			want.status           = gcme_pkg::ST_DONE;
			expected_cells = {expected_cells, want};
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(gcme_pkg::out_item_t got);
			gcme_pkg::out_item_t want;
			if (expected_cells.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_cells.pop_front();
			compare_field("tile_code", want.tile_code, got.tile_code);
			compare_field("column_clearance", want.column_clearance, got.column_clearance);
			compare_field("row_clearance", want.row_clearance, got.row_clearance);
			compare_field("status", want.status, got.status);
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	gcme_pkg::in_item_t         in_data;
	logic                       out_valid;
	logic                       out_stall;
	gcme_pkg::out_item_t        out_data;
	logic                       cfg_we;
	logic                       cfg_index;
	logic [gcme_pkg::CNT_W-1:0] cfg_data;

	clearance_scoreboard sb;
	int results_seen = 0;
	bit gaps_on = 1'b1;
	bit pressure_done = 1'b0;

	grid_clearance_map_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(in_data);
			if (out_valid && !out_stall) begin
				sb.check_reply(out_data);
				results_seen++;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off to back up the input
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!pressure_done && results_seen >= 300) begin
				pressure_done = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic gcme_pkg::in_item_t mk(logic [1:0] op, logic [5:0] x, logic [5:0] y,
			logic [15:0] v);
		gcme_pkg::in_item_t it;
		it.operation  = op;
		it.cell_x     = x;
		it.cell_y     = y;
		it.tile_value = v;
		return it;
	endfunction

	task automatic send_item(gcme_pkg::in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_gap(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [gcme_pkg::CNT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic set_grid(logic [gcme_pkg::CNT_W-1:0] w, logic [gcme_pkg::CNT_W-1:0] h);
		drain();
		write_reg(gcme_pkg::REG_GRID_WIDTH, w);
		write_reg(gcme_pkg::REG_GRID_HEIGHT, h);
	endtask

	task automatic run_random(int n);
		int unsigned w, h, big_rebuilds, r;
		gcme_pkg::in_item_t it;
		big_rebuilds = 0;
		for (int i = 0; i < n; i++) begin
			w = sb.eff_w();
			h = sb.eff_h();
			if (gaps_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 16));
			r = $urandom_range(0, 99);
			if (r < 52) it.operation = gcme_pkg::OP_WRITE;
			else if (r < 82) it.operation = gcme_pkg::OP_READ;
			else if (r < 90) it.operation = OP_SPARE;
			else if (w * h <= 256 || big_rebuilds < 3) begin
				it.operation = gcme_pkg::OP_REBUILD;
				if (w * h > 256) big_rebuilds++;
			end else it.operation = gcme_pkg::OP_READ;
			if ($urandom_range(0, 9) == 0) begin
				it.cell_x = 6'($urandom_range(0, 63));
				it.cell_y = 6'($urandom_range(0, 63));
			end else begin
				it.cell_x = 6'($urandom_range(0, w - 1));
				it.cell_y = 6'($urandom_range(0, h - 1));
			end
			r = $urandom_range(0, 19);
			if (r < 9) it.tile_value = '0;
			else if (r < 18) it.tile_value = 16'($urandom_range(1, 65535));
			else it.tile_value = 16'($urandom);
			send_item(it);
		end
	endtask

	initial begin
		sb = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = gcme_pkg::REG_GRID_WIDTH;
		cfg_data  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// full 64x64 grid, counts still zero at the first read, before any write or rebuild
		send_item(mk(gcme_pkg::OP_READ, 0, 0, 16'h0000));
		send_item(mk(gcme_pkg::OP_WRITE, 63, 63, 16'hFFFF));
		send_item(mk(OP_SPARE, 63, 63, 16'h0000));
		send_item(mk(gcme_pkg::OP_REBUILD, 0, 0, 16'h0000));
		send_item(mk(gcme_pkg::OP_WRITE, 0, 0, 16'h0001));
		send_item(mk(gcme_pkg::OP_WRITE, 0, 0, 16'h8000));
		send_item(mk(gcme_pkg::OP_WRITE, 0, 0, 16'h0000));
		send_item(mk(gcme_pkg::OP_WRITE, 63, 0, 16'h00FF));
		send_item(mk(gcme_pkg::OP_WRITE, 0, 63, 16'hFF00));
		send_item(mk(gcme_pkg::OP_READ, 62, 62, 16'hFFFF));
		send_item(mk(gcme_pkg::OP_WRITE, 63, 63, 16'h0000));
		send_item(mk(gcme_pkg::OP_REBUILD, 63, 63, 16'h0000));
		send_item(mk(gcme_pkg::OP_WRITE, 31, 31, 16'h5555));
		send_item(mk(gcme_pkg::OP_WRITE, 31, 31, 16'hAAAA));
		run_random(148);

		// zero registers act as a 1x1 grid
		set_grid(7'd0, 7'd0);
		send_item(mk(gcme_pkg::OP_WRITE, 1, 0, 16'hFFFF));
		send_item(mk(gcme_pkg::OP_READ, 0, 1, 16'h0000));
		send_item(mk(gcme_pkg::OP_REBUILD, 63, 63, 16'h0000));
		send_item(mk(gcme_pkg::OP_REBUILD, 0, 0, 16'h0000));
		send_item(mk(gcme_pkg::OP_WRITE, 0, 0, 16'h1234));
		send_item(mk(OP_SPARE, 0, 0, 16'h0000));
		send_item(mk(gcme_pkg::OP_WRITE, 0, 0, 16'h0000));
		run_random(60);

		set_grid(7'd127, 7'd127);
		run_random(148);
		set_grid(7'd64, 7'd1);
		run_random(148);
		set_grid(7'd1, 7'd64);
		run_random(148);
		gaps_on = 1'b0;
		set_grid(7'd8, 7'd8);
		run_random(148);
		gaps_on = 1'b1;
		set_grid(7'd65, 7'd3);
		run_random(148);
		for (int p = 0; p < 4; p++) begin
			set_grid(7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
					: $urandom_range(1, 16)),
				7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
					: $urandom_range(1, 16)));
			run_random(148);
		end
		gaps_on = 1'b0;
		set_grid(7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)));
		run_random(148);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
